### rtl/core/pcm_pkg.sv
package pcm_pkg;

  // Sizes of the block
  localparam int NUM_SOURCES = 5;
  localparam int VEL_WIDTH   = 16;
  localparam int SRC_W       = 3;
  localparam int STAMP_W     = 32;
  localparam int TIMEOUT_W   = 16;
  localparam int DB_W        = 15;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;

  // Magnitude compare width: room for |most negative| and for the deadband
  localparam int MAG_W = (VEL_WIDTH + 1 > DB_W) ? VEL_WIDTH + 1 : DB_W;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_RAW_W   = SRC_W + 3 * VEL_WIDTH + STAMP_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 3 * VEL_WIDTH + 1 + SRC_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Reset values of the registers
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(400);
  localparam logic [DB_W-1:0]      DEADBAND_RST = DB_W'(4);

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STALE_TIMEOUT = 1'b0,
    CFG_DEADBAND      = 1'b1
  } cfg_idx_t;

  // Item kinds
  typedef enum logic [0:0] {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef logic signed [VEL_WIDTH-1:0] vel_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [SRC_W-1:0]   source_index;
    vel_t               lin_x;
    vel_t               lin_y;
    vel_t               ang_z;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    vel_t             out_lin_x;
    vel_t             out_lin_y;
    vel_t             out_ang_z;
    logic             source_valid;
    logic [SRC_W-1:0] chosen_source;
  } result_t;

  // One component counts when its magnitude is strictly above the deadband
  function automatic logic comp_active(input vel_t v, input logic [DB_W-1:0] db);
    logic [VEL_WIDTH:0] ext;
    logic [VEL_WIDTH:0] mag;
    begin
      ext = {v[VEL_WIDTH-1], v};
      mag = v[VEL_WIDTH-1] ? (~ext + (VEL_WIDTH+1)'(1)) : ext;
      comp_active = MAG_W'(mag) > MAG_W'(db);
    end
  endfunction

  function automatic logic vel_active(input vel_t x, input vel_t y, input vel_t z,
                                      input logic [DB_W-1:0] db);
    vel_active = comp_active(x, db) | comp_active(y, db) | comp_active(z, db);
  endfunction

endpackage

### rtl/core/pcm_in_reg.sv
module pcm_in_reg
  import pcm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Take a beat whenever the register is empty or drains this cycle
  assign in_ready  = ~valid_r | advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/core/pcm_slot_bank.sv
module pcm_slot_bank
  import pcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  go,
  input  item_t                 item,
  output result_t               result
);

  logic [TIMEOUT_W-1:0]   timeout_r;
  logic [DB_W-1:0]        deadband_r;
  logic [NUM_SOURCES-1:0] valid_r;
  logic [NUM_SOURCES-1:0] valid_nxt;
  logic [NUM_SOURCES-1:0] fresh;
  logic [NUM_SOURCES-1:0] hit;
  logic [NUM_SOURCES-1:0] wr_slot;
  vel_t                   lx_r [NUM_SOURCES];
  vel_t                   ly_r [NUM_SOURCES];
  vel_t                   az_r [NUM_SOURCES];
  logic [STAMP_W-1:0]     stamp_r [NUM_SOURCES];
  logic                   cmd_active;
  logic [STAMP_W-1:0]     age;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      deadband_r <= DEADBAND_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_STALE_TIMEOUT: timeout_r  <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_DEADBAND:      deadband_r <= cfg_wdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd_active = vel_active(item.lin_x, item.lin_y, item.ang_z, deadband_r);

  // Per-slot decode, age check and eligibility
  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      age        = item.now_ms - stamp_r[i];
      fresh[i]   = valid_r[i] & ~(age > STAMP_W'(timeout_r));
      wr_slot[i] = (item.source_index == SRC_W'(i));
      hit[i]     = fresh[i] & vel_active(lx_r[i], ly_r[i], az_r[i], deadband_r);
    end
  end

  // Command sets or clears its slot; tick drops stale slots
  always_comb begin
    valid_nxt = valid_r;
    if (go) begin
      case (item.opcode)
        OP_CMD: begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (wr_slot[i]) valid_nxt[i] = cmd_active;
          end
        end
        OP_TICK: valid_nxt = fresh;
        default: valid_nxt = valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Slot payload, written only by an active command
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (go && item.opcode == OP_CMD && wr_slot[i] && cmd_active) begin
        lx_r[i]    <= item.lin_x;
        ly_r[i]    <= item.lin_y;
        az_r[i]    <= item.ang_z;
        stamp_r[i] <= item.now_ms;
      end
    end
  end

  // Fixed priority: lowest index wins, scan from the top index down
  always_comb begin
    result = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        result.out_lin_x     = lx_r[i];
        result.out_lin_y     = ly_r[i];
        result.out_ang_z     = az_r[i];
        result.source_valid  = 1'b1;
        result.chosen_source = SRC_W'(i);
      end
    end
  end

endmodule

### rtl/core/pcm_out_reg.sv
module pcm_out_reg
  import pcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // Room for a new beat when empty or the held one leaves now
  assign free = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

### rtl/core/priority_command_mux_with_timeout.sv
// Channel   Dir  Handshake          Payload
// in_       in   tvalid/tready      tuser: opcode; tdata: source, velocities, time
// out_      out  tvalid/tready      tdata: velocities, valid flag, chosen source
// cfg_      in   we (no wait)       addr: register index; wdata: value
//
// One beat per cycle unless a tick stalls. A beat held in the input register
// updates the slot bank; a tick's priority pick lands in the output register.
// A tick beat stalls in the input register only while the output register is
// full and out_tready is low; command beats never wait on the output side.
// Reset is synchronous, active low; it clears all slot valid bits and restores
// the timeout and deadband registers.
module priority_command_mux_with_timeout
  import pcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // [0] opcode
  input  logic [IN_DATA_W-1:0]  in_tdata,   // source_index, lin_x, lin_y, ang_z, now_ms
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_lin_x, out_lin_y, out_ang_z,
                                            // source_valid, chosen_source
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    out_free;
  result_t result;
  result_t out_result;

  // Unpack the input beat, lowest field first
  assign in_item.opcode       = opcode_t'(in_tuser);
  assign in_item.source_index = in_tdata[SRC_W-1:0];
  assign in_item.lin_x        = in_tdata[SRC_W +: VEL_WIDTH];
  assign in_item.lin_y        = in_tdata[SRC_W + VEL_WIDTH +: VEL_WIDTH];
  assign in_item.ang_z        = in_tdata[SRC_W + 2*VEL_WIDTH +: VEL_WIDTH];
  assign in_item.now_ms       = in_tdata[SRC_W + 3*VEL_WIDTH +: STAMP_W];

  // A held beat moves on unless it is a tick facing a full output
  assign advance = item_valid & ((item.opcode == OP_CMD) | out_free);

  pcm_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pcm_slot_bank u_slot_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .go        (advance),
    .item      (item),
    .result    (result)
  );

  pcm_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance & (item.opcode == OP_TICK)),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack the result beat, lowest field first, zero fill to whole bytes
  assign out_tdata = OUT_DATA_W'({out_result.chosen_source,
                                  out_result.source_valid,
                                  out_result.out_ang_z,
                                  out_result.out_lin_y,
                                  out_result.out_lin_x});

endmodule
